// File: rtl/core/cpi_pkg.sv
// Package for the cubic position-velocity-time interpolator.
// Holds the pipeline context type, stage numbers and arithmetic helpers.
// No dependencies.
package cpi_pkg;

    localparam int NUM_STAGES = 76;
    localparam int K_SDIV_LAST = 33;
    localparam int K_MUL1_PP = 34;
    localparam int K_MUL1_SUM = 35;
    localparam int K_ADD1 = 36;
    localparam int K_MUL2_PP = 37;
    localparam int K_MUL2_SUM = 38;
    localparam int K_ADD2 = 39;
    localparam int K_MUL3_PP = 40;
    localparam int K_MUL3_SUM = 41;
    localparam int K_VDIV_FIRST = 42;
    localparam int K_VDIV_LAST = 74;
    localparam int K_FINAL = 75;

    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [31:0] v0;
        logic signed [31:0] p1;
        logic signed [31:0] v1;
        logic [31:0]        tm;
        logic [31:0]        tau;
        logic               zero;
        logic signed [53:0] b;
        logic signed [53:0] e;
        logic signed [53:0] d;
        logic signed [53:0] a;
        logic signed [53:0] c;
        logic signed [53:0] c3;
        logic signed [53:0] w;
        logic [32:0]        s;
        logic [31:0]        rs;
        logic signed [60:0] pah;
        logic signed [61:0] pal;
        logic signed [60:0] pbh;
        logic signed [61:0] pbl;
        logic signed [53:0] ma;
        logic signed [53:0] mb;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic [52:0]        vabs;
        logic               vneg;
        logic               vovf;
        logic [31:0]        vr;
        logic [32:0]        vq;
    } t_ctx;

    // One restoring division step: returns the quotient bit over the new remainder.
    function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                             input logic [31:0] d);
        logic [32:0] r2;
        logic [32:0] res;
        r2 = {r, b};
        if (r2 >= {1'b0, d}) begin
            res = {1'b1, 32'(r2 - {1'b0, d})};
        end else begin
            res = {1'b0, r2[31:0]};
        end
        return res;
    endfunction

    function automatic logic signed [60:0] pp_hi(input logic signed [53:0] x,
                                                 input logic [32:0] s);
        return 61'($signed(x[53:27])) * 61'($signed({1'b0, s}));
    endfunction

    function automatic logic signed [61:0] pp_lo(input logic signed [53:0] x,
                                                 input logic [32:0] s);
        return 62'($signed({1'b0, x[26:0]})) * 62'($signed({1'b0, s}));
    endfunction

    // Combines the partial products and drops 32 fraction bits with floor rounding.
    function automatic logic signed [53:0] mul_fin(input logic signed [60:0] h,
                                                   input logic signed [61:0] l);
        logic signed [88:0] t;
        t = (89'(h) <<< 27) + 89'(l);
        return $signed(t[85:32]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [53:0] x);
        logic signed [31:0] r;
        if (x > 54'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -54'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cubic_pvt_interpolator.sv
// Top level of the cubic position-velocity-time interpolator.
// A single pipeline of context registers; depends on cpi_pkg.
//
//   channel   direction   handshake             payload
//   input     in          i_valid / o_stall     start/end pos and vel, seg and eval time
//   output    out         o_valid / i_stall     pos, vel, clamped time, zero duration
//
// One transfer is accepted every cycle while o_stall is low.
// The pipeline holds two bit-serial division pipelines of 33 stages each
// and three chained two-stage multiplies.
// Reset clears only the stage valid bits. A stall while a result waits at the
// output holds every stage and raises o_stall at the input.
module cubic_pvt_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_pos,
    input  logic signed [31:0] i_start_vel,
    input  logic signed [31:0] i_end_pos,
    input  logic signed [31:0] i_end_vel,
    input  logic [31:0]        i_seg_time,
    input  logic [31:0]        i_eval_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_out,
    output logic signed [31:0] o_vel_out,
    output logic [31:0]        o_time_out,
    output logic               o_zero_duration
);

    localparam int NS = cpi_pkg::NUM_STAGES;

    cpi_pkg::t_ctx r_pl [NS];
    cpi_pkg::t_ctx n_pl [NS];
    logic [NS-1:0] r_vld;
    logic          w_en;

    assign w_en    = !r_vld[NS-1] || !i_stall;
    assign o_stall = !w_en;

    always_comb begin
        n_pl[0]      = '0;
        n_pl[0].p0   = i_start_pos;
        n_pl[0].v0   = i_start_vel;
        n_pl[0].p1   = i_end_pos;
        n_pl[0].v1   = i_end_vel;
        n_pl[0].tm   = i_seg_time;
        n_pl[0].tau  = (i_eval_time > i_seg_time) ? i_seg_time : i_eval_time;
        n_pl[0].zero = (i_seg_time == 32'd0);
        n_pl[0].rs   = {1'b0, n_pl[0].tau[31:1]};
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int S_BIT = (k <= cpi_pkg::K_SDIV_LAST) ? cpi_pkg::K_SDIV_LAST - k : 0;
        localparam int Q_BIT = (k >= cpi_pkg::K_VDIV_FIRST && k <= cpi_pkg::K_VDIV_LAST) ?
                               cpi_pkg::K_VDIV_LAST - k : 0;
        localparam int A_BIT = (Q_BIT >= 16) ? Q_BIT - 16 : 0;

        always_comb begin
            logic [32:0]        st;
            logic signed [64:0] prb;
            logic signed [64:0] pre;
            logic signed [35:0] mag;
            cpi_pkg::t_ctx      c;
            c   = r_pl[k-1];
            st  = '0;
            prb = '0;
            pre = '0;
            mag = '0;
            if (k <= cpi_pkg::K_SDIV_LAST) begin
                st = cpi_pkg::div_step(c.rs, (k == 1) ? c.tau[0] : 1'b0, c.tm);
                c.rs = st[31:0];
                c.s[S_BIT] = st[32];
            end
            if (k == 1) begin
                prb = 65'(c.v0) * 65'($signed({1'b0, c.tm}));
                pre = 65'(c.v1) * 65'($signed({1'b0, c.tm}));
                c.b = 54'(prb >>> 16);
                c.e = 54'(pre >>> 16);
                c.d = 54'(c.p1) - 54'(c.p0);
            end
            if (k == 2) begin
                c.a  = (c.d <<< 1) + c.d - (c.b <<< 1) - c.e;
                c.c  = c.b + c.e - (c.d <<< 1);
                c.c3 = ((c.b + c.e) <<< 1) + c.b + c.e - (c.d <<< 2) - (c.d <<< 1);
            end
            if (k == cpi_pkg::K_MUL1_PP) begin
                c.pah = cpi_pkg::pp_hi(c.c, c.s);
                c.pal = cpi_pkg::pp_lo(c.c, c.s);
                c.pbh = cpi_pkg::pp_hi(c.c3, c.s);
                c.pbl = cpi_pkg::pp_lo(c.c3, c.s);
            end
            if (k == cpi_pkg::K_MUL1_SUM || k == cpi_pkg::K_MUL2_SUM ||
                k == cpi_pkg::K_MUL3_SUM) begin
                c.ma = cpi_pkg::mul_fin(c.pah, c.pal);
                c.mb = cpi_pkg::mul_fin(c.pbh, c.pbl);
            end
            if (k == cpi_pkg::K_ADD1) begin
                c.w = (c.a <<< 1) + c.mb;
                c.a = c.a + c.ma;
            end
            if (k == cpi_pkg::K_MUL2_PP) begin
                c.pah = cpi_pkg::pp_hi(c.a, c.s);
                c.pal = cpi_pkg::pp_lo(c.a, c.s);
                c.pbh = cpi_pkg::pp_hi(c.w, c.s);
                c.pbl = cpi_pkg::pp_lo(c.w, c.s);
            end
            if (k == cpi_pkg::K_ADD2) begin
                c.a = c.b + c.ma;
                c.w = c.b + c.mb;
            end
            if (k == cpi_pkg::K_MUL3_PP) begin
                c.pah  = cpi_pkg::pp_hi(c.a, c.s);
                c.pal  = cpi_pkg::pp_lo(c.a, c.s);
                c.vneg = c.w[53];
                c.vabs = c.w[53] ? 53'(-c.w) : c.w[52:0];
            end
            if (k == cpi_pkg::K_MUL3_SUM) begin
                c.vovf = ({4'b0, c.tm} <= c.vabs[52:17]) ? 1'b1 : 1'b0;
                c.vr   = c.vabs[48:17];
            end
            if (k == cpi_pkg::K_VDIV_FIRST) begin
                c.pos = cpi_pkg::sat32(54'(c.p0) + c.ma);
            end
            if (k >= cpi_pkg::K_VDIV_FIRST && k <= cpi_pkg::K_VDIV_LAST) begin
                st = cpi_pkg::div_step(c.vr, (Q_BIT >= 16) ? c.vabs[A_BIT] : 1'b0, c.tm);
                c.vr = st[31:0];
                c.vq[Q_BIT] = st[32];
            end
            if (k == cpi_pkg::K_FINAL) begin
                mag = $signed({3'b0, c.vq}) +
                      ((c.vneg && c.vr != 32'd0) ? 36'sd1 : 36'sd0);
                if (c.vovf) begin
                    c.vel = c.vneg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else begin
                    c.vel = cpi_pkg::sat32(c.vneg ? 54'(-mag) : 54'(mag));
                end
                if (c.zero) begin
                    c.pos = c.p0;
                    c.vel = c.v0;
                    c.tau = 32'd0;
                end
            end
            n_pl[k] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NS; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    assign o_valid         = r_vld[NS-1];
    assign o_pos_out       = r_pl[NS-1].pos;
    assign o_vel_out       = r_pl[NS-1].vel;
    assign o_time_out      = r_pl[NS-1].tau;
    assign o_zero_duration = r_pl[NS-1].zero;

endmodule
